>>> hw/rtl/lmfs_pkg.sv
// Shared widths, operation codes and the queued request record for the frame scroller.
package lmfs_pkg;

  localparam int FUNC_W = 3;
  localparam int COL_W  = 6;
  localparam int ROW_W  = 3;
  localparam int DATA_W = 8;
  localparam int REG_W  = 4;
  localparam int SLOT_W = 3;
  localparam int CNT_W  = 4;

  localparam logic [CNT_W-1:0] CNT_RESET = 4'd8;
  localparam logic [REG_W-1:0] ADDR_NOP  = 4'd0;

  localparam int Q_DEPTH = 2;
  localparam int QPW     = $clog2(Q_DEPTH);
  localparam int QCW     = $clog2(Q_DEPTH + 1);

  typedef enum logic [FUNC_W-1:0] {
    OP_COMMAND    = 3'd0,
    OP_SET_COLUMN = 3'd1,
    OP_SET_DOT    = 3'd2,
    OP_LEFT       = 3'd3,
    OP_RIGHT      = 3'd4,
    OP_UP         = 3'd5,
    OP_DOWN       = 3'd6,
    OP_CLEAR      = 3'd7
  } lmfs_op_t;

  typedef struct packed {
    lmfs_op_t            op;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic [DATA_W-1:0]   val;
    logic [REG_W-1:0]    reg_sel;
    logic                rot;
    logic                fz;
    logic [SLOT_W-1:0]   nm1;
  } lmfs_cmd_t;

endpackage

>>> hw/rtl/lmfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lmfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/lmfs_front.sv
// Front end: takes requests, holds the chip count register and builds queue records.
module lmfs_front #(
  parameter int MAX_DEVICES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [lmfs_pkg::FUNC_W-1:0]   in_func,
  input  logic [lmfs_pkg::COL_W-1:0]    in_column,
  input  logic [lmfs_pkg::ROW_W-1:0]    in_row,
  input  logic [lmfs_pkg::DATA_W-1:0]   in_value,
  input  logic [lmfs_pkg::REG_W-1:0]    in_reg_select,
  input  logic                          in_rotate,
  input  logic                          in_fill_zero,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lmfs_pkg::CNT_W-1:0]    cfg_device_count,
  input  logic                          q_full,
  output logic                          q_push,
  output lmfs_pkg::lmfs_cmd_t           q_cmd
);
  import lmfs_pkg::*;

  localparam logic [COL_W-1:0] COL_MASK = COL_W'(MAX_DEVICES * 8 - 1);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_DEVICES);

  logic [CNT_W-1:0]  dev_count_r;
  logic [CNT_W-1:0]  dev_count_nxt;
  logic [SLOT_W-1:0] nm1;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;
  assign q_push    = start && !q_full;

  always_comb begin
    dev_count_nxt = dev_count_r;
    if (cfg_valid && cfg_ready) begin
      dev_count_nxt = cfg_device_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_count_r <= CNT_RESET;
    end else begin
      dev_count_r <= dev_count_nxt;
    end
  end

  // A count of zero behaves as one chip; a count above the chain length is capped.
  always_comb begin
    priority if (dev_count_r == '0) begin
      nm1 = '0;
    end else if (dev_count_r > MAX_CNT) begin
      nm1 = SLOT_W'(MAX_CNT - CNT_W'(1));
    end else begin
      nm1 = SLOT_W'(dev_count_r - CNT_W'(1));
    end
  end

  always_comb begin
    q_cmd.op      = lmfs_op_t'(in_func);
    q_cmd.col     = in_column & COL_MASK;
    q_cmd.row     = in_row;
    q_cmd.val     = in_value;
    q_cmd.reg_sel = in_reg_select;
    q_cmd.rot     = in_rotate;
    q_cmd.fz      = in_fill_zero;
    q_cmd.nm1     = nm1;
  end

endmodule

>>> hw/rtl/lmfs_queue.sv
// Two-entry request queue between the front end and the execution engine.
module lmfs_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lmfs_pkg::lmfs_cmd_t  push_cmd,
  input  logic                 pop,
  output lmfs_pkg::lmfs_cmd_t  head,
  output logic                 full,
  output logic                 empty
);
  import lmfs_pkg::*;

  lmfs_cmd_t        q_r [Q_DEPTH];
  logic [QPW-1:0]   wp_r;
  logic [QPW-1:0]   rp_r;
  logic [QCW-1:0]   cnt_r;
  logic [QPW-1:0]   wp_nxt;
  logic [QPW-1:0]   rp_nxt;
  logic [QCW-1:0]   cnt_nxt;

  assign full  = (cnt_r == QCW'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = wp_r + QPW'(1);
    end
    if (pop) begin
      rp_nxt = rp_r + QPW'(1);
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + QCW'(1);
      2'b01:   cnt_nxt = cnt_r - QCW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_cmd;
    end
  end

endmodule

>>> hw/rtl/lmfs_back.sv
// Execution engine: column store, shift sweeps and register word emission.
module lmfs_back #(
  parameter int MAX_DEVICES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  lmfs_pkg::lmfs_cmd_t           q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  output logic [lmfs_pkg::REG_W-1:0]    out_word_address,
  output logic [lmfs_pkg::DATA_W-1:0]   out_word_data,
  output logic [lmfs_pkg::SLOT_W-1:0]   out_device_slot,
  output logic                          out_latch,
  output logic                          out_last
);
  import lmfs_pkg::*;

  localparam int DEPTH = MAX_DEVICES * 8;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0]    LAST     = AW'(DEPTH - 1);
  localparam logic [COL_W-1:0] COL_MASK = COL_W'(DEPTH - 1);

  typedef enum logic [2:0] {
    B_IDLE, B_DISPATCH, B_DOT, B_SWEEP, B_DRAIN, B_FINAL, B_EMIT
  } state_t;

  typedef enum logic [1:0] {EK_CMD, EK_SINGLE, EK_RELOAD} kind_t;

  typedef struct packed {
    logic               valid;
    logic [REG_W-1:0]   addr;
    logic [DATA_W-1:0]  data;
    logic [SLOT_W-1:0]  slot;
    logic               latch;
    logic               last;
    logic               from_ram;
  } word_t;

  state_t            st_r, st_nxt;
  kind_t             kind_r, kind_nxt;
  lmfs_cmd_t         cmd_r, cmd_nxt;
  logic [AW-1:0]     k_r, k_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pk_r, pk_nxt;
  logic [DATA_W-1:0] old_r, old_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [SLOT_W-1:0] r_r, r_nxt;
  logic [SLOT_W-1:0] s_r, s_nxt;
  word_t             e_r, e_nxt;
  logic [DEPTH-1:0]  vld_r, vld_nxt;
  logic              rv_r;

  logic              out_valid_r;
  logic [REG_W-1:0]  out_addr_r;
  logic [DATA_W-1:0] out_data_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_latch_r;
  logic              out_last_r;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] rd;
  logic              clear_all;

  logic [COL_W-1:0]  used_full;
  logic [AW-1:0]     used_m1;
  logic [AW-1:0]     col_a;
  logic [COL_W-1:0]  rl_idx;

  logic              ret_we;
  logic [AW-1:0]     ret_waddr;
  logic [DATA_W-1:0] ret_wdata;
  logic              ret_cap;

  logic              sweep_done;
  logic              w_latch;
  logic              w_fin;
  logic [DATA_W-1:0] bit_mask;

  lmfs_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Entries never written since reset or clear read as zero.
  assign rd        = rv_r ? ram_rdata : '0;
  assign used_full = {cmd_r.nm1, 3'b111};
  assign used_m1   = used_full[AW-1:0];
  assign col_a     = cmd_r.col[AW-1:0];
  assign rl_idx    = {s_r, r_r} & COL_MASK;
  assign bit_mask  = DATA_W'(1) << cmd_r.row;

  // Retire the read issued in the previous sweep cycle.
  always_comb begin
    ret_we    = 1'b0;
    ret_waddr = pk_r;
    ret_wdata = rd;
    ret_cap   = 1'b0;
    if (pend_r) begin
      unique case (cmd_r.op)
        OP_LEFT: begin
          if (pk_r == '0) begin
            ret_cap = 1'b1;
          end else begin
            ret_we    = 1'b1;
            ret_waddr = pk_r - AW'(1);
            if (ret_waddr == used_m1) begin
              ret_wdata = cmd_r.rot ? old_r : (cmd_r.fz ? '0 : rd);
            end
          end
        end
        OP_RIGHT: begin
          ret_cap   = (pk_r == used_m1);
          ret_we    = (pk_r != LAST);
          ret_waddr = pk_r + AW'(1);
        end
        OP_UP: begin
          ret_we    = 1'b1;
          ret_wdata = {cmd_r.rot & rd[DATA_W-1-7], rd[DATA_W-1:1]};
        end
        OP_DOWN: begin
          ret_we    = 1'b1;
          ret_wdata = {rd[DATA_W-2:0], cmd_r.rot & rd[DATA_W-1]};
        end
        default: begin
          ret_we = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    priority if (cmd_r.op == OP_RIGHT) begin
      sweep_done = (k_r == '0);
    end else if (cmd_r.op == OP_UP || cmd_r.op == OP_DOWN) begin
      sweep_done = (k_r == used_m1);
    end else begin
      sweep_done = (k_r == LAST);
    end
  end

  assign w_latch = (s_r == cmd_r.nm1);
  assign w_fin   = w_latch && (kind_r != EK_RELOAD || r_r == SLOT_W'(7));

  always_comb begin
    st_nxt    = st_r;
    kind_nxt  = kind_r;
    cmd_nxt   = cmd_r;
    k_nxt     = k_r;
    pend_nxt  = pend_r;
    pk_nxt    = pk_r;
    old_nxt   = old_r;
    data_nxt  = data_r;
    r_nxt     = r_r;
    s_nxt     = s_r;
    e_nxt     = '0;
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    clear_all = 1'b0;

    unique case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head;
          st_nxt  = B_DISPATCH;
        end
      end
      B_DISPATCH: begin
        r_nxt    = '0;
        s_nxt    = '0;
        pend_nxt = 1'b0;
        kind_nxt = EK_RELOAD;
        unique case (cmd_r.op)
          OP_COMMAND: begin
            kind_nxt = EK_CMD;
            st_nxt   = B_EMIT;
          end
          OP_SET_COLUMN: begin
            ram_we    = 1'b1;
            ram_waddr = col_a;
            ram_wdata = cmd_r.val;
            data_nxt  = cmd_r.val;
            kind_nxt  = EK_SINGLE;
            st_nxt    = B_EMIT;
          end
          OP_SET_DOT: begin
            ram_raddr = col_a;
            st_nxt    = B_DOT;
          end
          OP_RIGHT: begin
            k_nxt  = LAST;
            st_nxt = B_SWEEP;
          end
          OP_CLEAR: begin
            clear_all = 1'b1;
            st_nxt    = B_EMIT;
          end
          default: begin
            k_nxt  = '0;
            st_nxt = B_SWEEP;
          end
        endcase
      end
      B_DOT: begin
        ram_we    = 1'b1;
        ram_waddr = col_a;
        ram_wdata = cmd_r.val[0] ? (rd | bit_mask) : (rd & ~bit_mask);
        data_nxt  = ram_wdata;
        kind_nxt  = EK_SINGLE;
        st_nxt    = B_EMIT;
      end
      B_SWEEP: begin
        ram_raddr = k_r;
        pend_nxt  = 1'b1;
        pk_nxt    = k_r;
        ram_we    = ret_we;
        ram_waddr = ret_waddr;
        ram_wdata = ret_wdata;
        if (ret_cap) begin
          old_nxt = rd;
        end
        if (sweep_done) begin
          st_nxt = B_DRAIN;
        end else if (cmd_r.op == OP_RIGHT) begin
          k_nxt = k_r - AW'(1);
        end else begin
          k_nxt = k_r + AW'(1);
        end
      end
      B_DRAIN: begin
        pend_nxt  = 1'b0;
        ram_we    = ret_we;
        ram_waddr = ret_waddr;
        ram_wdata = ret_wdata;
        if (ret_cap) begin
          old_nxt = rd;
        end
        st_nxt = (cmd_r.op == OP_LEFT || cmd_r.op == OP_RIGHT) ? B_FINAL : B_EMIT;
      end
      B_FINAL: begin
        // Left refills the top column; right refills column zero unless it keeps its value.
        if (cmd_r.op == OP_LEFT) begin
          ram_we    = 1'b1;
          ram_waddr = LAST;
          ram_wdata = (LAST == used_m1 && cmd_r.rot) ? old_r : '0;
        end else begin
          ram_we    = cmd_r.rot || cmd_r.fz;
          ram_waddr = '0;
          ram_wdata = cmd_r.rot ? old_r : '0;
        end
        st_nxt = B_EMIT;
      end
      B_EMIT: begin
        e_nxt.valid = 1'b1;
        e_nxt.slot  = s_r;
        e_nxt.latch = w_latch;
        e_nxt.last  = w_fin;
        unique case (kind_r)
          EK_CMD: begin
            e_nxt.addr = cmd_r.reg_sel;
            e_nxt.data = cmd_r.val;
          end
          EK_SINGLE: begin
            if (s_r == cmd_r.col[COL_W-1:3]) begin
              e_nxt.addr = {1'b0, cmd_r.col[2:0]} + REG_W'(1);
              e_nxt.data = data_r;
            end else begin
              e_nxt.addr = ADDR_NOP;
              e_nxt.data = '0;
            end
          end
          default: begin
            e_nxt.addr     = {1'b0, r_r} + REG_W'(1);
            e_nxt.from_ram = 1'b1;
            ram_raddr      = rl_idx[AW-1:0];
          end
        endcase
        if (w_latch) begin
          s_nxt = '0;
          r_nxt = r_r + SLOT_W'(1);
        end else begin
          s_nxt = s_r + SLOT_W'(1);
        end
        if (w_fin) begin
          st_nxt = B_IDLE;
        end
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase
  end

  always_comb begin
    vld_nxt = vld_r;
    if (ram_we) begin
      vld_nxt[ram_waddr] = 1'b1;
    end
    if (clear_all) begin
      vld_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      pend_r      <= 1'b0;
      e_r.valid   <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      pend_r      <= pend_nxt;
      e_r         <= e_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= e_r.valid;
    end
    kind_r      <= kind_nxt;
    cmd_r       <= cmd_nxt;
    k_r         <= k_nxt;
    pk_r        <= pk_nxt;
    old_r       <= old_nxt;
    data_r      <= data_nxt;
    r_r         <= r_nxt;
    s_r         <= s_nxt;
    rv_r        <= vld_r[ram_raddr];
    out_addr_r  <= e_r.addr;
    out_data_r  <= e_r.from_ram ? rd : e_r.data;
    out_slot_r  <= e_r.slot;
    out_latch_r <= e_r.latch;
    out_last_r  <= e_r.last;
  end

  assign out_valid        = out_valid_r;
  assign out_word_address = out_addr_r;
  assign out_word_data    = out_data_r;
  assign out_device_slot  = out_slot_r;
  assign out_latch        = out_latch_r;
  assign out_last         = out_last_r;

endmodule

>>> hw/rtl/led_matrix_frame_scroller.sv
// Engine time per request is set by the store sweep and by word emission at one word per cycle;
// up, down, left and right sweep the store before the first word, the other requests do not.
// Two requests queue ahead of the engine; busy is high while the queue is full.
// Reset is synchronous, active low: the store reads as zero and the chip count returns to 8.
module led_matrix_frame_scroller #(
  parameter int MAX_DEVICES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [lmfs_pkg::FUNC_W-1:0]   in_func,
  input  logic [lmfs_pkg::COL_W-1:0]    in_column,
  input  logic [lmfs_pkg::ROW_W-1:0]    in_row,
  input  logic [lmfs_pkg::DATA_W-1:0]   in_value,
  input  logic [lmfs_pkg::REG_W-1:0]    in_reg_select,
  input  logic                          in_rotate,
  input  logic                          in_fill_zero,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lmfs_pkg::CNT_W-1:0]    cfg_device_count,
  output logic                          out_valid,
  output logic [lmfs_pkg::REG_W-1:0]    out_word_address,
  output logic [lmfs_pkg::DATA_W-1:0]   out_word_data,
  output logic [lmfs_pkg::SLOT_W-1:0]   out_device_slot,
  output logic                          out_latch,
  output logic                          out_last
);
  import lmfs_pkg::*;

  lmfs_cmd_t push_cmd;
  lmfs_cmd_t head;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;

  lmfs_front #(.MAX_DEVICES(MAX_DEVICES)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_column        (in_column),
    .in_row           (in_row),
    .in_value         (in_value),
    .in_reg_select    (in_reg_select),
    .in_rotate        (in_rotate),
    .in_fill_zero     (in_fill_zero),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_device_count (cfg_device_count),
    .q_full           (full),
    .q_push           (push),
    .q_cmd            (push_cmd)
  );

  lmfs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  lmfs_back #(.MAX_DEVICES(MAX_DEVICES)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (empty),
    .q_head           (head),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_word_address (out_word_address),
    .out_word_data    (out_word_data),
    .out_device_slot  (out_device_slot),
    .out_latch        (out_latch),
    .out_last         (out_last)
  );

endmodule

>>> hw/rtl/lmfs_checker.sv
// Port-level checks on frame structure of the scroller output, bound to the top level.
module lmfs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          busy,
  input logic                          out_valid,
  input logic [lmfs_pkg::SLOT_W-1:0]   out_device_slot,
  input logic                          out_latch,
  input logic                          out_last
);

  // The final word of a request always closes a frame.
  a_last_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_latch)
    else $error("last word without latch");

  // Words inside a frame come on consecutive cycles with rising slot numbers.
  a_slot_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_latch |=> out_valid &&
      out_device_slot == $past(out_device_slot) + 3'd1)
    else $error("frame word missing or out of order");

  // Frames of one request follow each other directly, each starting at slot zero.
  a_frame_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_latch && !out_last |=> out_valid && out_device_slot == 3'd0)
    else $error("next frame did not start at slot zero");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("word directly after the last word of a request");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("output or busy active after reset");

endmodule

bind led_matrix_frame_scroller lmfs_checker u_lmfs_checker (.*);
